@@ rtl/rrpf_pkg.sv @@
// Shared types and constants for the rounded rectangle pattern fill block.
package rrpf_pkg;

   localparam int COORD_IN_W  = 16;
   localparam int SCREEN_W    = 13;
   localparam int PITCH_W     = 14;
   localparam int PATTERN_W   = 32;
   localparam int PIX_ADDR_W  = 25;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PITCH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_UPPER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOWER = 3'd4;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;
   localparam logic [PITCH_W-1:0]  ROW_PITCH_RESET     = 14'd640;

   typedef struct packed {
      logic                          operation;
      logic signed [COORD_IN_W-1:0]  rect_left;
      logic signed [COORD_IN_W-1:0]  rect_top;
      logic signed [COORD_IN_W-1:0]  rect_right;
      logic signed [COORD_IN_W-1:0]  rect_bottom;
      logic signed [COORD_IN_W-1:0]  oval_width;
   } req_type;

   typedef struct packed {
      logic                  write_valid;
      logic [PIX_ADDR_W-1:0] pixel_address;
      logic                  is_black;
      logic                  shape_done;
   } rsp_type;

   typedef struct packed {
      logic [SCREEN_W-1:0]  screen_width;
      logic [SCREEN_W-1:0]  screen_height;
      logic [PITCH_W-1:0]   row_pitch_pixels;
      logic [PATTERN_W-1:0] pattern_rows_upper;
      logic [PATTERN_W-1:0] pattern_rows_lower;
   } cfg_type;

endpackage

@@ rtl/rrpf_csr.sv @@
// Configuration register file of the pattern fill block.
module rrpf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrpf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rrpf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output rrpf_pkg::cfg_type                    cfg
);

   rrpf_pkg::cfg_type cfg_ff;
   rrpf_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rrpf_pkg::CSR_SCREEN_WIDTH: begin
               cfg_in.screen_width = csr_wdata[rrpf_pkg::SCREEN_W-1:0];
            end
            rrpf_pkg::CSR_SCREEN_HEIGHT: begin
               cfg_in.screen_height = csr_wdata[rrpf_pkg::SCREEN_W-1:0];
            end
            rrpf_pkg::CSR_ROW_PITCH: begin
               cfg_in.row_pitch_pixels = csr_wdata[rrpf_pkg::PITCH_W-1:0];
            end
            rrpf_pkg::CSR_PATTERN_UPPER: begin
               cfg_in.pattern_rows_upper = csr_wdata[rrpf_pkg::PATTERN_W-1:0];
            end
            rrpf_pkg::CSR_PATTERN_LOWER: begin
               cfg_in.pattern_rows_lower = csr_wdata[rrpf_pkg::PATTERN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width       <= rrpf_pkg::SCREEN_WIDTH_RESET;
         cfg_ff.screen_height      <= rrpf_pkg::SCREEN_HEIGHT_RESET;
         cfg_ff.row_pitch_pixels   <= rrpf_pkg::ROW_PITCH_RESET;
         cfg_ff.pattern_rows_upper <= '0;
         cfg_ff.pattern_rows_lower <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/rrpf_front.sv @@
// Front end: rectangle clipping, corner radius and the raster cursor.
module rrpf_front #(
   parameter int MAX_DIM = 4096,
   parameter int CW      = 13,
   parameter int EW      = 65
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rrpf_pkg::req_type    req,
   input  rrpf_pkg::cfg_type    cfg,
   output logic [EW-1:0]        entry
);

   localparam int RW = CW - 1;

   typedef struct packed {
      logic          has_pix;
      logic          done;
      logic          in_corner;
      logic [RW-1:0] dx;
      logic [RW-1:0] dy;
      logic [RW-1:0] rad;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
   } entry_type;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cursor_x_ff, cursor_x_in;
   logic [CW-1:0] cursor_y_ff, cursor_y_in;
   logic [CW-1:0] clip_left_ff, clip_left_in;
   logic [CW-1:0] clip_top_ff, clip_top_in;
   logic [CW-1:0] clip_right_ff, clip_right_in;
   logic [CW-1:0] clip_bottom_ff, clip_bottom_in;
   logic [RW-1:0] radius_ff, radius_in;

   // Load path
   logic [CW-1:0]        sw_eff, sh_eff;
   logic signed [16:0]   l17, t17, r17, b17, sw17, sh17, rc17, bc17;
   logic                 empty;
   logic [CW-1:0]        width_c, height_c;
   logic [15:0]          rad_req, half_w, half_h, rad_a, rad_b;

   // Step path
   logic [CW-1:0] left_edge, top_edge, right_edge, bottom_edge;
   logic          cx, rx, ty, by;
   logic [CW-1:0] x_next, y_next;
   entry_type     ent;

   always_comb begin
      sw_eff = (32'(cfg.screen_width) > 32'(MAX_DIM)) ? CW'(MAX_DIM)
                                                     : CW'(cfg.screen_width);
      sh_eff = (32'(cfg.screen_height) > 32'(MAX_DIM)) ? CW'(MAX_DIM)
                                                      : CW'(cfg.screen_height);
      sw17 = signed'(17'(sw_eff));
      sh17 = signed'(17'(sh_eff));
      l17  = req.rect_left[15] ? 17'sd0 : 17'(req.rect_left);
      t17  = req.rect_top[15]  ? 17'sd0 : 17'(req.rect_top);
      r17  = 17'(req.rect_right);
      b17  = 17'(req.rect_bottom);
      rc17 = (r17 > sw17) ? sw17 : r17;
      bc17 = (b17 > sh17) ? sh17 : b17;
      empty = (l17 >= rc17) || (t17 >= bc17);
      width_c  = CW'(rc17 - l17);
      height_c = CW'(bc17 - t17);
      half_w   = 16'(width_c >> 1);
      half_h   = 16'(height_c >> 1);
      rad_req  = req.oval_width[15] ? 16'd0 : {1'b0, req.oval_width[15:1]};
      rad_a    = (rad_req > half_w) ? half_w : rad_req;
      rad_b    = (rad_a > half_h) ? half_h : rad_a;
   end

   always_comb begin
      left_edge   = clip_left_ff + CW'(radius_ff);
      top_edge    = clip_top_ff + CW'(radius_ff);
      right_edge  = clip_right_ff - CW'(radius_ff);
      bottom_edge = clip_bottom_ff - CW'(radius_ff);
      cx = cursor_x_ff < left_edge;
      rx = cursor_x_ff >= right_edge;
      ty = cursor_y_ff < top_edge;
      by = cursor_y_ff >= bottom_edge;
      x_next = cursor_x_ff + CW'(1);
      y_next = cursor_y_ff + CW'(1);
   end

   always_comb begin
      busy_in        = busy_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_right_in  = clip_right_ff;
      clip_bottom_in = clip_bottom_ff;
      radius_in      = radius_ff;

      ent.has_pix   = 1'b0;
      ent.done      = 1'b0;
      ent.in_corner = (cx | rx) & (ty | by);
      ent.dx        = cx ? RW'(left_edge - cursor_x_ff)
                         : RW'(cursor_x_ff - right_edge + CW'(1));
      ent.dy        = ty ? RW'(top_edge - cursor_y_ff)
                         : RW'(cursor_y_ff - bottom_edge + CW'(1));
      ent.rad       = radius_ff;
      ent.x         = cursor_x_ff;
      ent.y         = cursor_y_ff;

      if (push) begin
         if (req.operation == rrpf_pkg::OP_LOAD) begin
            ent.done = empty;
            if (empty) begin
               busy_in = 1'b0;
            end else begin
               busy_in        = 1'b1;
               clip_left_in   = CW'(l17);
               clip_top_in    = CW'(t17);
               clip_right_in  = CW'(rc17);
               clip_bottom_in = CW'(bc17);
               radius_in      = RW'(rad_b);
               cursor_x_in    = CW'(l17);
               cursor_y_in    = CW'(t17);
            end
         end else if (!busy_ff) begin
            ent.done = 1'b1;
         end else begin
            ent.has_pix = 1'b1;
            if (x_next >= clip_right_ff) begin
               if (y_next >= clip_bottom_ff) begin
                  ent.done = 1'b1;
                  busy_in  = 1'b0;
               end else begin
                  cursor_x_in = clip_left_ff;
                  cursor_y_in = y_next;
               end
            end else begin
               cursor_x_in = x_next;
            end
         end
      end
   end

   assign entry = EW'(ent);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         cursor_x_ff    <= '0;
         cursor_y_ff    <= '0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= '0;
         clip_bottom_ff <= '0;
         radius_ff      <= '0;
      end else begin
         busy_ff        <= busy_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_right_ff  <= clip_right_in;
         clip_bottom_ff <= clip_bottom_in;
         radius_ff      <= radius_in;
      end
   end

endmodule

@@ rtl/rrpf_queue.sv @@
// Small first-in first-out queue between the front end and the back end.
module rrpf_queue #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/rrpf_back.sv @@
// Back end: corner distance test, pixel address, pattern colour and result word.
module rrpf_back #(
   parameter int CW         = 13,
   parameter int EW         = 65,
   parameter int ADDR_WIDTH = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  logic [EW-1:0]        q_data,
   output logic                 q_pop,
   input  rrpf_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rrpf_pkg::rsp_type    rsp_data
);

   localparam int RW     = CW - 1;
   localparam int SQ_W   = 2 * RW;
   localparam int PROD_W = CW + rrpf_pkg::PITCH_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int AOUT_W = rrpf_pkg::PIX_ADDR_W;
   localparam logic [SUM_W-1:0] ADDR_MASK =
      (ADDR_WIDTH >= SUM_W) ? {SUM_W{1'b1}} : SUM_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   typedef struct packed {
      logic          has_pix;
      logic          done;
      logic          in_corner;
      logic [RW-1:0] dx;
      logic [RW-1:0] dy;
      logic [RW-1:0] rad;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
   } entry_type;

   entry_type ent;

   // First stage: squares, row product and pattern lookup
   logic              a_valid_ff, a_valid_in;
   logic              a_has_ff, a_corner_ff, a_done_ff, a_bit_ff;
   logic [SQ_W-1:0]   a_dx2_ff, a_dy2_ff, a_r2_ff;
   logic [PROD_W-1:0] a_prod_ff;
   logic [CW-1:0]     a_x_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   rrpf_pkg::rsp_type rsp_ff, rsp_in;

   logic              b_ready, a_ready;
   logic [2:0]        pat_row;
   logic [31:0]       pat_word;
   logic [7:0]        pat_byte;
   logic              pat_bit;
   logic [SQ_W:0]     dist2;
   logic              pix_kept;
   logic [SUM_W-1:0]  addr_full;

   assign ent     = entry_type'(q_data);
   assign b_ready = !rsp_valid_ff || !rsp_stall;
   assign a_ready = !a_valid_ff || b_ready;
   assign q_pop   = !q_empty && a_ready;

   always_comb begin
      pat_row  = ent.y[2:0];
      pat_word = pat_row[2] ? cfg.pattern_rows_lower : cfg.pattern_rows_upper;
      pat_byte = pat_word[pat_row[1:0]*8 +: 8];
      pat_bit  = pat_byte[3'd7 - ent.x[2:0]];
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_ready) begin
         a_valid_in = q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_has_ff    <= ent.has_pix;
         a_corner_ff <= ent.in_corner;
         a_done_ff   <= ent.done;
         a_bit_ff    <= pat_bit;
         a_dx2_ff    <= SQ_W'(ent.dx) * SQ_W'(ent.dx);
         a_dy2_ff    <= SQ_W'(ent.dy) * SQ_W'(ent.dy);
         a_r2_ff     <= SQ_W'(ent.rad) * SQ_W'(ent.rad);
         a_prod_ff   <= PROD_W'(ent.y) * PROD_W'(cfg.row_pitch_pixels);
         a_x_ff      <= ent.x;
      end
   end

   always_comb begin
      dist2     = (SQ_W + 1)'(a_dx2_ff) + (SQ_W + 1)'(a_dy2_ff);
      pix_kept  = !a_corner_ff || (dist2 <= (SQ_W + 1)'(a_r2_ff));
      addr_full = (SUM_W'(a_prod_ff) + SUM_W'(a_x_ff)) & ADDR_MASK;

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (b_ready) begin
         rsp_valid_in         = a_valid_ff;
         rsp_in.write_valid   = a_has_ff & pix_kept;
         rsp_in.pixel_address = (a_has_ff & pix_kept) ? AOUT_W'(addr_full) : '0;
         rsp_in.is_black      = a_has_ff & pix_kept & a_bit_ff;
         rsp_in.shape_done    = a_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/rounded_rect_pattern_fill_top.sv @@
// Top level of the rounded rectangle pattern fill rasteriser.
//
//   Channel   Direction  Handshake            Word
//   req_      in         req_valid/req_stall  rrpf_pkg::req_type (load or step)
//   rsp_      out        rsp_valid/rsp_stall  rrpf_pkg::rsp_type (one per request)
//   csr_      in         csr_valid/csr_ready  register index and 32-bit data
//
// A request word is taken at every edge where the queue has room, so words may
// follow back to back; its response word passes through the queue slot, the squaring
// stage and the result register, and is held there while rsp_stall is high.
// Clipping and the cursor settle in the cycle of acceptance, so a step may follow a load.
// Reset clears the scan state and pipeline flags and restores 640 by 480, pitch 640.
// A response stall fills the four-entry queue; req_stall then rises until a word drains.
module rounded_rect_pattern_fill_top #(
   parameter int MAX_DIM    = 4096,
   parameter int ADDR_WIDTH = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rrpf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rrpf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rrpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Coordinates hold values up to MAX_DIM itself, since the right and bottom
   // clip bounds are exclusive. The corner radius never exceeds half of that.
   localparam int CW         = $clog2(MAX_DIM + 1);
   localparam int RW         = CW - 1;
   localparam int EW         = 3 + 3 * RW + 2 * CW;
   localparam int QUEUE_DEPTH = 4;

   rrpf_pkg::cfg_type cfg;
   logic              push, q_full, q_empty, q_pop;
   logic [EW-1:0]     front_entry, q_data;

   rrpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A request is taken whenever the queue can hold its decoded word.
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   rrpf_front #(
      .MAX_DIM (MAX_DIM),
      .CW      (CW),
      .EW      (EW)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .req   (req_data),
      .cfg   (cfg),
      .entry (front_entry)
   );

   rrpf_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end reads the pitch and pattern straight from the registers;
   // these must only change while no word is in flight, which the block does not enforce.
   rrpf_back #(
      .CW         (CW),
      .EW         (EW),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
